>>> src/fp32hr_pkg.sv
// Package for the fp32 horizontal reduction block: operation codes and
// the single-precision add and compare functions. No dependencies.
package fp32hr_pkg;

  localparam int unsigned LaneCount = 16;

  typedef enum logic [1:0] {
    OP_SUM16 = 2'd0,
    OP_SUM8  = 2'd1,
    OP_MAX16 = 2'd2,
    OP_MIN16 = 2'd3
  } op_e;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  // IEEE single add, round to nearest even, denormals kept.
  function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a, b;
    logic        sa, sb;
    logic [8:0]  ea, eb, e, d;
    logic [27:0] ma, mb, m, lost_mask;
    logic [2:0]  rb;
    logic [4:0]  lz;
    logic [24:0] mr;
    logic [31:0] res;
    a = a_in;
    b = b_in;
    res = '0;
    lz = '0;
    if (a_in[30:0] < b_in[30:0]) begin
      a = b_in;
      b = a_in;
    end
    sa = a[31];
    sb = b[31];
    ea = {1'b0, a[30:23]};
    eb = {1'b0, b[30:23]};
    ma = {4'd0, (ea != 9'd0), a[22:0]} << 3;
    mb = {4'd0, (eb != 9'd0), b[22:0]} << 3;
    if (ea == 9'd0) ea = 9'd1;
    if (eb == 9'd0) eb = 9'd1;
    d = ea - eb;
    if (d >= 9'd27) begin
      mb = {27'd0, (mb != 28'd0)};
    end else if (d != 9'd0) begin
      lost_mask = (28'd1 << d[4:0]) - 28'd1;
      mb = (mb >> d[4:0]) | {27'd0, ((mb & lost_mask) != 28'd0)};
    end
    e = ea;
    if (sa == sb) begin
      m = ma + mb;
      if (m[27]) begin
        m = (m >> 1) | {27'd0, m[0]};
        e = e + 9'd1;
      end
    end else begin
      m = ma - mb;
      // Leading-zero count for renormalization, bounded by the exponent.
      for (int i = 26; i >= 0; i--) begin
        if (m[i] && lz == 5'd0 && m[26:0] >> (i + 1) == 27'd0) lz = 5'(26 - i);
      end
      if (m == 28'd0) lz = 5'd0;
      if ({4'd0, lz} > e - 9'd1) lz = 5'(e - 9'd1);
      m = m << lz;
      e = e - {4'd0, lz};
    end
    rb = m[2:0];
    mr = m[27:3];
    if (rb > 3'd4 || (rb == 3'd4 && mr[0])) mr = mr + 25'd1;
    if (mr[24]) begin
      mr = mr >> 1;
      e = e + 9'd1;
    end
    if (e >= 9'd255) res = {sa, 8'hFF, 23'd0};
    else res = {sa, (mr[23] ? e[7:0] : 8'd0), mr[22:0]};
    if (sa != sb && m == 28'd0) res = '0;
    if (a[30:0] == 31'd0) res = a & b;
    if (b_in[30:0] == 31'h7F80_0000) res = b_in;
    if (a_in[30:0] == 31'h7F80_0000) begin
      if (b_in[30:0] == 31'h7F80_0000 && (a_in[31] ^ b_in[31])) res = 32'hFFC0_0000;
      else res = a_in;
    end
    if (is_nan(b_in)) res = b_in | 32'h0040_0000;
    if (is_nan(a_in)) res = a_in | 32'h0040_0000;
    return res;
  endfunction

  function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka, kb;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
    return ka < kb;
  endfunction

  function automatic logic [31:0] combine(input op_e op, input logic [31:0] a,
                                          input logic [31:0] b);
    case (op)
      OP_MAX16: return fp_less(b, a) ? a : b;
      OP_MIN16: return fp_less(a, b) ? a : b;
      default:  return fp_add(a, b);
    endcase
  endfunction

endpackage

>>> src/fp32_horizontal_reduce.sv
// Channel   Direction  Signals
// request   in         req_valid_i/req_ready_o, req_type_i, lanes_*_i
// result    out        res_valid_o/res_ready_i, reduced_value_o
// Four register stages, one per level of the pairwise tree; one vector
// enters per cycle while req_ready_o is high, and its result is registered
// in s1_q, s2_q, s3_q and s4_q in turn before it is offered.
// Each stage holds while the stage after it is full and stalled, so a
// stall loses and repeats nothing. Reset clears the valid bits only.
// Depends on fp32hr_pkg.
module fp32_horizontal_reduce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] lanes_0_1_i,
  input  logic [63:0] lanes_2_3_i,
  input  logic [63:0] lanes_4_5_i,
  input  logic [63:0] lanes_6_7_i,
  input  logic [63:0] lanes_8_9_i,
  input  logic [63:0] lanes_10_11_i,
  input  logic [63:0] lanes_12_13_i,
  input  logic [63:0] lanes_14_15_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [31:0] reduced_value_o
);
  import fp32hr_pkg::*;

  logic [31:0] in_lane [16];
  logic [31:0] s1_d [8], s1_q [8];
  logic [31:0] s2_d [4], s2_q [4];
  logic [31:0] s3_d [2], s3_q [2];
  logic [31:0] s4_d, s4_q;
  op_e op1_q, op2_q, op3_q, op_in;
  logic [3:0] vld_q;
  logic [3:0] adv;

  assign op_in = op_e'(req_type_i);
  assign in_lane = '{lanes_0_1_i[31:0], lanes_0_1_i[63:32], lanes_2_3_i[31:0],
                     lanes_2_3_i[63:32], lanes_4_5_i[31:0], lanes_4_5_i[63:32],
                     lanes_6_7_i[31:0], lanes_6_7_i[63:32], lanes_8_9_i[31:0],
                     lanes_8_9_i[63:32], lanes_10_11_i[31:0], lanes_10_11_i[63:32],
                     lanes_12_13_i[31:0], lanes_12_13_i[63:32], lanes_14_15_i[31:0],
                     lanes_14_15_i[63:32]};

  // A stage may load when it is empty or its content moves on this cycle.
  assign adv[3] = !vld_q[3] || res_ready_i;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign req_ready_o = adv[0];
  assign res_valid_o = vld_q[3];
  assign reduced_value_o = s4_q;

  always_comb begin
    // The 8-lane sum takes upper half plus lower half in the first level;
    // lanes 4..7 pass through; level two keeps sums 0..3, the rest is shared.
    for (int k = 0; k < 8; k++) begin
      if (op_in == OP_SUM8) begin
        s1_d[k] = (k < 4) ? fp_add(in_lane[k + 4], in_lane[k]) : in_lane[k];
      end else begin
        s1_d[k] = combine(op_in, in_lane[k], in_lane[k + 8]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      s2_d[k] = (op1_q == OP_SUM8) ? s1_q[k] : combine(op1_q, s1_q[k], s1_q[k + 4]);
    end
    for (int k = 0; k < 2; k++) s3_d[k] = combine(op2_q, s2_q[k], s2_q[k + 2]);
    s4_d = combine(op3_q, s3_q[0], s3_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= req_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && req_valid_i) begin
      s1_q <= s1_d;
      op1_q <= op_in;
    end
    if (adv[1] && vld_q[0]) begin
      s2_q <= s2_d;
      op2_q <= op1_q;
    end
    if (adv[2] && vld_q[1]) begin
      s3_q <= s3_d;
      op3_q <= op2_q;
    end
    if (adv[3] && vld_q[2]) s4_q <= s4_d;
  end

endmodule

>>> src/fp32hr_checker.sv
// Port-level checker for fp32_horizontal_reduce, attached by bind.
// Depends only on the top level's ports.
module fp32hr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_o,
  input logic        res_valid_o,
  input logic        res_ready_i,
  input logic [31:0] reduced_value_o
);
  // A result that waits keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(reduced_value_o))
    else $error("result changed while stalled");
  // With the output free the pipe never refuses a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ready_i |-> req_ready_o)
    else $error("input blocked while output drains");
  // Reset keeps the result channel idle: a clock edge seen in reset is followed by no offered result.
  assert property (@(posedge clk_i) !rst_ni |=> !res_valid_o)
    else $error("result valid in reset");
  // An accepted vector, with the output held ready, is offered once it has
  // passed through every stage of the pipe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o && res_ready_i ##1 res_ready_i ##1 res_ready_i
    ##1 res_ready_i |=> res_valid_o)
    else $error("result missing after four cycles");
endmodule

bind fp32_horizontal_reduce fp32hr_checker u_fp32hr_checker (.*);
